// ----- hdl/kth_largest_stream_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the k-th largest stream tracker
// Shared helpers for the concurrent checks on the block ports.
// ----------------------------------------------------------------------------
`ifndef KTH_LARGEST_STREAM_TRACKER_MACROS_SVH
`define KTH_LARGEST_STREAM_TRACKER_MACROS_SVH

// Generic clocked check, switched off while reset is low
`define KLS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Signal must hold while a word is offered and not taken
`define KLS_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> $stable(sig)) \
    else $error("%m: stalled signal changed");

`endif

// ----- hdl/kls_pkg.sv -----
// ----------------------------------------------------------------------------
// kls_pkg
// Types and fixed constants of the k-th largest stream tracker.
// ----------------------------------------------------------------------------
package kls_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 7;
  localparam logic [RANK_W-1:0] RANK_RESET = 7'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUTE,
    S_UP_CMP,
    S_DN_CMP,
    S_PUT,
    S_DONE
  } state_e;

endpackage

// ----- hdl/kls_in_if.sv -----
// ----------------------------------------------------------------------------
// kls_in_if
// Input channel: one set element per word, with end-of-set flag.
// ----------------------------------------------------------------------------
interface kls_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [kls_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- hdl/kls_out_if.sv -----
// ----------------------------------------------------------------------------
// kls_out_if
// Result channel: k-th largest value of a finished set and short flag.
// ----------------------------------------------------------------------------
interface kls_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [kls_pkg::VALUE_W-1:0] kth_value;
  logic                               short_set;

  modport source (output valid, output kth_value, output short_set, input ready);
  modport sink   (input valid, input kth_value, input short_set, output ready);
endinterface

// ----- hdl/kth_largest_stream_tracker.sv -----
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker
// Tracks the k largest values of a set and reports the k-th on set end.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i carries one signed element per word; last marks the end of a set.
//  - out_o carries one word per finished set: the k-th largest value and
//    short_set, raised when the set held fewer than k values (the smallest
//    value of the set is then given).
//  - cfg_we_i/cfg_wdata_i write rank_k (1 = maximum); 0 acts as 1, values
//    above MAX_RANK act as MAX_RANK. Write only while the block is idle.
//  - Values sit in a binary min-heap held in a two-read-port RAM; the root is
//    mirrored in a register. Each word is one heap insert or one
//    replace-the-minimum, walking one heap level per cycle; a word not
//    above the minimum of a full heap is dropped. Words are taken one at
//    a time, the next only once the last one's sift walk is done; in_i.ready
//    is high only while idle.
//  - Reset clears the fill count and selects rank 1; no RAM clearing pass.
//  - A stalled result is held in the output register; the next set may be
//    taken meanwhile, and the block only waits if a second result is ready
//    before the first has gone.
// ----------------------------------------------------------------------------
module kth_largest_stream_tracker #(
  parameter int MAX_RANK   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kls_pkg::RANK_W-1:0]  cfg_wdata_i,
  kls_in_if.sink                      in_i,
  kls_out_if.source                   out_o
);

  localparam int AW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CW  = $clog2(MAX_RANK + 1);
  localparam int IXW = AW + 2;  // child index, may run past the heap end

  kls_pkg::state_e state_q, state_d;

  logic [kls_pkg::RANK_W-1:0] rank_q;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              k_eff;
  logic [AW-1:0]              pos_q, pos_d;
  logic signed [VALUE_BITS-1:0] v_q, root_q, root_d;
  logic                       last_q;

  logic                         out_valid_q, out_valid_d;
  logic signed [kls_pkg::VALUE_W-1:0] out_kth_q;
  logic                         out_short_q;
  logic                         out_load;

  // heap RAM
  logic                  we;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] wdata, rdata_a, rdata_b;
  logic signed [VALUE_BITS-1:0] ch_a, ch_b;

  // sift-down helpers
  logic [IXW-1:0]        c1, c2, nc1;
  logic                  c2_ok;
  logic [AW-1:0]         child;
  logic signed [VALUE_BITS-1:0] child_v;

  kls_heap_ram #(
    .DEPTH (MAX_RANK),
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign ch_a = signed'(rdata_a);
  assign ch_b = signed'(rdata_b);

  // rank clamp to 1..MAX_RANK
  always_comb begin
    if (rank_q == '0) begin
      k_eff = CW'(1);
    end else if (int'(rank_q) >= MAX_RANK) begin
      k_eff = CW'(MAX_RANK);
    end else begin
      k_eff = CW'(rank_q);
    end
  end

  // children of the current slot; smaller one wins
  assign c1      = {1'b0, pos_q, 1'b1};
  assign c2      = c1 + IXW'(1);
  assign c2_ok   = c2 < IXW'(count_q);
  assign child   = (c2_ok && (ch_b < ch_a)) ? AW'(c2) : AW'(c1);
  assign child_v = (c2_ok && (ch_b < ch_a)) ? ch_b : ch_a;
  assign nc1     = {1'b0, child, 1'b1};

  assign in_i.ready = (state_q == kls_pkg::S_IDLE);
  assign out_load   = (state_q == kls_pkg::S_DONE) && last_q &&
                      (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    root_d  = root_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = v_q;
    raddr_a = '0;
    raddr_b = '0;

    case (state_q)
      kls_pkg::S_IDLE: begin
        if (in_i.valid) begin
          state_d = kls_pkg::S_ROUTE;
        end
      end

      kls_pkg::S_ROUTE: begin
        if (count_q < k_eff) begin
          // append at the heap end and sift up
          count_d = count_q + CW'(1);
          pos_d   = AW'(count_q);
          if (count_q == '0) begin
            we      = 1'b1;
            waddr   = '0;
            root_d  = v_q;
            state_d = kls_pkg::S_DONE;
          end else begin
            raddr_a = AW'((count_q - CW'(1)) >> 1);
            state_d = kls_pkg::S_UP_CMP;
          end
        end else if (v_q > root_q) begin
          // replace the minimum and sift down from the root
          pos_d = '0;
          if (count_q == CW'(1)) begin
            we      = 1'b1;
            waddr   = '0;
            root_d  = v_q;
            state_d = kls_pkg::S_DONE;
          end else begin
            raddr_a = AW'(1);
            raddr_b = AW'(2);
            state_d = kls_pkg::S_DN_CMP;
          end
        end else begin
          state_d = kls_pkg::S_DONE;
        end
      end

      kls_pkg::S_UP_CMP: begin
        // rdata_a holds the parent of pos_q
        if (v_q < ch_a) begin
          we      = 1'b1;
          waddr   = pos_q;
          wdata   = rdata_a;
          pos_d   = (pos_q - AW'(1)) >> 1;
          if (pos_d == '0) begin
            state_d = kls_pkg::S_PUT;
          end else begin
            raddr_a = (pos_d - AW'(1)) >> 1;
          end
        end else begin
          we      = 1'b1;
          state_d = kls_pkg::S_DONE;
        end
      end

      kls_pkg::S_DN_CMP: begin
        // rdata_a/rdata_b hold the children of pos_q
        if (child_v < v_q) begin
          we    = 1'b1;
          wdata = child_v;
          if (pos_q == '0) begin
            root_d = child_v;
          end
          pos_d = child;
          if (nc1 < IXW'(count_q)) begin
            raddr_a = AW'(nc1);
            raddr_b = AW'(nc1 + IXW'(1));
          end else begin
            state_d = kls_pkg::S_PUT;
          end
        end else begin
          we = 1'b1;
          if (pos_q == '0) begin
            root_d = v_q;
          end
          state_d = kls_pkg::S_DONE;
        end
      end

      kls_pkg::S_PUT: begin
        we = 1'b1;
        if (pos_q == '0) begin
          root_d = v_q;
        end
        state_d = kls_pkg::S_DONE;
      end

      kls_pkg::S_DONE: begin
        if (!last_q) begin
          state_d = kls_pkg::S_IDLE;
        end else if (out_load) begin
          count_d = '0;
          state_d = kls_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = kls_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kls_pkg::S_IDLE;
      count_q     <= '0;
      rank_q      <= kls_pkg::RANK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    root_q <= root_d;
    if (in_i.valid && in_i.ready) begin
      v_q    <= VALUE_BITS'(in_i.value);
      last_q <= in_i.last;
    end
    if (out_load) begin
      out_kth_q   <= kls_pkg::VALUE_W'(root_q);
      out_short_q <= count_q < k_eff;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kth_value = out_kth_q;
  assign out_o.short_set = out_short_q;

endmodule

// ----- hdl/kls_heap_ram.sv -----
// ----------------------------------------------------------------------------
// kls_heap_ram
// Heap storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kls_heap_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // out-of-range read addresses only occur for unused sibling reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- hdl/kls_checker.sv -----
// ----------------------------------------------------------------------------
// kls_checker
// Port-level checks for the k-th largest stream tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "kth_largest_stream_tracker_macros.svh"

module kls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_kth_value,
  input logic        out_short_set
);

  // whole result word, value and short flag
  logic [32:0] out_word;

  assign out_word = {out_kth_value, out_short_set};

  // a taken word closes the input in the next cycle
  `KLS_ASSERT(a_busy_after_take, clk_i, rst_ni, (in_valid && in_ready) |=> !in_ready)

  // a result never appears the cycle after a word is taken
  `KLS_ASSERT(a_no_instant_result, clk_i, rst_ni, (in_valid && in_ready && !out_valid) |=> !out_valid)

  // results are loaded only while the input is closed
  `KLS_ASSERT(a_load_while_busy, clk_i, rst_ni, $rose(out_valid) |-> $past(!in_ready))

  `KLS_ASSERT(a_out_valid_holds, clk_i, rst_ni, (out_valid && !out_ready) |=> out_valid)

  `KLS_ASSERT_HOLD(a_out_kth_holds, clk_i, rst_ni, out_valid, out_ready, out_word)

endmodule

bind kth_largest_stream_tracker kls_checker u_kls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_kth_value (out_o.kth_value),
  .out_short_set (out_o.short_set)
);

// ----- sim/tb_kth_largest_stream_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_kth_largest_stream_tracker
// Self-checking bench for the k-th largest stream tracker: a short table of
// directed words, then random sets over many rank settings. Every result word
// is checked against a bit-true min-store predictor, or a typed row's value.
// ----------------------------------------------------------------------------
module tb_kth_largest_stream_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RANK     = 64;
  // Drain wait after the last word, with a good margin over the sift walk
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_WORDS = 1800;
  localparam int REPORT_LIMIT = 10;
  localparam int IDLE_PCT     = 19;
  // Random phases CALM_FIRST to CALM_LAST run with both sides flat out
  localparam int CALM_FIRST   = 4;
  localparam int CALM_LAST    = 7;
  // Watchdog, far beyond the slowest legal run (about 0.5 ms)
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef logic [kls_pkg::RANK_W-1:0] rank_t;

  typedef struct packed {
    logic signed [kls_pkg::VALUE_W-1:0] kth_value;
    logic                               short_set;
  } kth_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_RANK
  } row_kind_e;

  // One directed step: either a set element or a rank write (rank in the
  // low bits of value). Where typed is set, the expectation is read off the
  // row instead of the predictor.
  typedef struct packed {
    row_kind_e                          kind;
    logic signed [kls_pkg::VALUE_W-1:0] value;
    logic                               last;
    logic                               typed;
    logic signed [kls_pkg::VALUE_W-1:0] kth_value;
    logic                               short_set;
  } stim_row_t;

  localparam int NUM_ROWS = 28;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // rank 1 straight out of reset: single-word set gives the word back
    '{ROW_WORD, 32'sd5,           1'b1, 1'b1, 32'sd5,           1'b0},
    // value extremes, maximum wins
    '{ROW_WORD, 32'sh7FFFFFFF,    1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sh80000000,    1'b1, 1'b1, 32'sh7FFFFFFF,    1'b0},
    // rank 0 behaves as rank 1
    '{ROW_RANK, 32'sd0,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, -32'sd1,          1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, -32'sd2,          1'b1, 1'b1, -32'sd1,          1'b0},
    // rank 3: duplicates each take a place
    '{ROW_RANK, 32'sd3,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd10,          1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd10,          1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd10,          1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd3,           1'b1, 1'b1, 32'sd10,          1'b0},
    // short sets: smallest of the set, short flag up
    '{ROW_WORD, -32'sd7,          1'b1, 1'b1, -32'sd7,          1'b1},
    '{ROW_WORD, 32'sh80000000,    1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd1,           1'b1, 1'b1, 32'sh80000000,    1'b1},
    // rank 127 clamps to the store depth
    '{ROW_RANK, 32'sd127,         1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd0,           1'b1, 1'b1, 32'sd0,           1'b1},
    // rank raised part-way through a set
    '{ROW_RANK, 32'sd2,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd4,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd9,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_RANK, 32'sd5,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd1,           1'b1, 1'b1, 32'sd1,           1'b1},
    // rank lowered part-way through: the store does not shrink
    '{ROW_RANK, 32'sd4,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd1,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd2,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd3,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd4,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_RANK, 32'sd1,           1'b0, 1'b0, 32'sd0,           1'b0},
    '{ROW_WORD, 32'sd0,           1'b1, 1'b0, 32'sd0,           1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  rank_t       cfg_wdata;
  bit          no_idle = 1'b0;
  int unsigned words_sent = 0;
  int unsigned fail_count = 0;

  // Predictor state: kept values, fill level and the rank register copy
  logic signed [kls_pkg::VALUE_W-1:0] kept_model [MAX_RANK];
  int unsigned                        fill_model = 0;
  rank_t                              rank_model = kls_pkg::RANK_RESET;
  kth_result_t                        pending_kth [$];

  kls_in_if  in_ch ();
  kls_out_if out_ch ();

  kth_largest_stream_tracker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Slot of the smallest kept value (first one on a tie)
  function automatic int unsigned smallest_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < fill_model; i++)
      if (kept_model[i] < kept_model[best]) best = i;
    return best;
  endfunction

  // Inserts one element; returns 1 and the result when it closes a set
  function automatic bit track_value(input logic signed [kls_pkg::VALUE_W-1:0] v,
                                     input logic l, output kth_result_t res);
    int unsigned k;
    int unsigned m;
    // rank clamped to 1..MAX_RANK
    k = (rank_model == 0) ? 1 : ((rank_model > MAX_RANK) ? MAX_RANK : rank_model);
    res = '0;
    if (fill_model < k) begin
      kept_model[fill_model] = v;
      fill_model++;
    end else begin
      // store full (or grown past a lowered rank): insert, then drop the min
      m = smallest_slot();
      if (v > kept_model[m]) kept_model[m] = v;
    end
    if (!l) return 1'b0;
    res.kth_value = kept_model[smallest_slot()];
    res.short_set = (fill_model < k);
    fill_model = 0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one word, with random idle cycles ahead of it, and books the
  // expectation once the handshake has gone through.
  task automatic push_word(input logic signed [kls_pkg::VALUE_W-1:0] v, input logic l,
                           input bit typed, input kth_result_t typed_res);
    kth_result_t res;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (track_value(v, l, res)) pending_kth.push_back(typed ? typed_res : res);
    words_sent++;
  endtask

  // Holds the sender off until every result is out, then lets the last
  // sift walk finish (a word without last leaves nothing to wait for).
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_kth.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rank(input rank_t r);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    rank_model = r;
    cfg_we <= 1'b0;
  endtask

  // Result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  initial begin
    kth_result_t got;
    kth_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kth_value = out_ch.kth_value;
        got.short_set = out_ch.short_set;
        if (pending_kth.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: result word with none expected: kth_value=%0d short_set=%0b",
                     $time, got.kth_value, got.short_set);
          fail_count++;
        end else begin
          want = pending_kth.pop_front();
          if (got !== want) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: mismatch: kth_value exp %0d got %0d, short_set exp %0b got %0b",
                       $time, want.kth_value, got.kth_value, want.short_set,
                       got.short_set);
            fail_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    kth_result_t                        typed_res;
    logic signed [kls_pkg::VALUE_W-1:0] v;
    rank_t                              rank;
    int unsigned                        target;
    int unsigned                        phase;
    int unsigned                        keff;
    int unsigned                        n_sets;
    int unsigned                        len;
    int unsigned                        split;
    int unsigned                        style;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_RANK) begin
        write_rank(DIRECTED[i].value[kls_pkg::RANK_W-1:0]);
      end else begin
        typed_res.kth_value = DIRECTED[i].kth_value;
        typed_res.short_set = DIRECTED[i].short_set;
        push_word(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed, typed_res);
      end
    end

    // Random sets: each phase picks a rank, then runs a handful of sets of
    // lengths around that rank so both full and short stores are common.
    target = words_sent + RANDOM_WORDS;
    phase  = 0;
    while (words_sent < target) begin
      phase++;
      if (phase == 1) begin
        rank = 7'd64;
      end else if (phase == 2) begin
        rank = 7'd65;
      end else begin
        case ($urandom_range(3))
          0, 1: rank = rank_t'($urandom_range(1, 8));
          2: rank = rank_t'($urandom_range(9, 64));
          default: begin
            case ($urandom_range(5))
              0: rank = 7'd0;
              1: rank = 7'd1;
              2: rank = 7'd63;
              3: rank = 7'd64;
              4: rank = 7'd65;
              default: rank = 7'd127;
            endcase
          end
        endcase
      end
      write_rank(rank);
      no_idle = (phase >= CALM_FIRST && phase <= CALM_LAST);
      keff    = (rank == 0) ? 1 : ((rank > MAX_RANK) ? MAX_RANK : rank);
      n_sets  = $urandom_range(3, 8);

      for (int s = 0; s < n_sets; s++) begin
        // mostly sets near the rank, some very short ones as noise
        if ($urandom_range(99) < 85) len = $urandom_range(1, 2 * keff + 1);
        else len = $urandom_range(1, 3);
        style = $urandom_range(2);
        // now and then the rank moves mid-set
        split = (len > 1 && $urandom_range(7) == 0) ? $urandom_range(1, len - 1) : 0;

        for (int w = 0; w < len; w++) begin
          if (split != 0 && w == split) write_rank(rank_t'($urandom_range(0, 127)));
          case (style)
            0: v = $urandom;
            // narrow range, plenty of duplicates
            1: v = $signed($urandom_range(16)) - 8;
            default: begin
              case ($urandom_range(4))
                0: v = 32'sh7FFFFFFF;
                1: v = 32'sh80000000;
                2: v = 32'sd0;
                3: v = -32'sd1;
                default: v = $urandom;
              endcase
            end
          endcase
          push_word(v, (w == len - 1), 1'b0, '0);
        end
      end
    end

    no_idle = 1'b0;
    wait_idle();
    if (fail_count == 0 && pending_kth.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/kls_pkg.sv
hdl/kls_in_if.sv
hdl/kls_out_if.sv
hdl/kls_heap_ram.sv
hdl/kth_largest_stream_tracker.sv
hdl/kls_checker.sv
sim/tb_kth_largest_stream_tracker.sv
